// ----- sv/hunk_executable_parser_assert.svh -----
// Assertion macros for the hunk parser RTL.
// Each macro expects clk and rst_n in scope of the module that uses it.
`ifndef HUNK_EXECUTABLE_PARSER_ASSERT_SVH
`define HUNK_EXECUTABLE_PARSER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define HEP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define HEP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/hep_pkg.sv -----
// Shared types and constants for the hunk executable parser.
// No dependencies.
package hep_pkg;

  localparam logic [31:0] TYPE_CODE   = 32'h0000_03E9;
  localparam logic [31:0] TYPE_DATA   = 32'h0000_03EA;
  localparam logic [31:0] TYPE_BSS    = 32'h0000_03EB;
  localparam logic [31:0] TYPE_RELOC  = 32'h0000_03EC;
  localparam logic [31:0] TYPE_SYMBOL = 32'h0000_03F0;
  localparam logic [31:0] TYPE_END    = 32'h0000_03F2;
  localparam logic [31:0] TYPE_HEADER = 32'h0000_03F3;

  localparam logic [1:0] KIND_SIZE  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_RELOC = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] hunk_index;
    logic [31:0] dest_hunk;
    logic [31:0] value;
  } hep_result_t;

endpackage

// ----- sv/hunk_executable_parser.sv -----
// Hunk executable stream parser: one longword per item, at most one result per item.
// A word is held in the input register and its result in the result register, which drives the out ports.
// Throughput: one word per cycle; a word that yields a result waits only on a full result reg not being read.
// Reset (synchronous, active low) clears parse state, counters, halt flag and both valids.
// Depends on hep_pkg, hep_in_reg, hep_parse and hep_out_reg.
module hunk_executable_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [15:0] out_hunk_index,
  output logic [31:0] out_dest_hunk,
  output logic [31:0] out_value
);
  import hep_pkg::*;

  logic        word_valid;
  logic [31:0] word;
  logic        emit;
  logic        free;
  logic        take;
  hep_result_t res;

  // advance the held word unless its result has nowhere to go
  assign take = word_valid && (!emit || free);

  hep_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_word    (in_word),
    .take       (take),
    .word_valid (word_valid),
    .word       (word)
  );

  hep_parse u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .word  (word),
    .take  (take),
    .emit  (emit),
    .res   (res)
  );

  hep_out_reg u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (take && emit),
    .res            (res),
    .free           (free),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_hunk_index (out_hunk_index),
    .out_dest_hunk  (out_dest_hunk),
    .out_value      (out_value)
  );

endmodule

// ----- sv/hep_in_reg.sv -----
// Input register stage of the hunk parser: holds one word until consumed.
// Depends on nothing but the clock and reset.
module hep_in_reg (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_word,
  input  logic        take,
  output logic        word_valid,
  output logic [31:0] word
);

  logic        valid_r;
  logic [31:0] word_r;

  assign in_ready   = !valid_r || take;
  assign word_valid = valid_r;
  assign word       = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_r <= in_word;
    end
  end

endmodule

// ----- sv/hep_parse.sv -----
// Hunk structure tracker: parse state, counters and result formation.
// Depends on hep_pkg and hunk_executable_parser_assert.svh.
`include "hunk_executable_parser_assert.svh"

module hep_parse (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [31:0]         word,
  input  logic                take,
  output logic                emit,
  output hep_pkg::hep_result_t res
);
  import hep_pkg::*;

  typedef enum logic [15:0] {
    M_TYPE        = 16'h0001,
    M_LIB_LEN     = 16'h0002,
    M_LIB_SKIP    = 16'h0004,
    M_TBL_SIZE    = 16'h0008,
    M_FIRST       = 16'h0010,
    M_LAST        = 16'h0020,
    M_TABLE       = 16'h0040,
    M_CODE_SIZE   = 16'h0080,
    M_BSS_SIZE    = 16'h0100,
    M_CONTENT     = 16'h0200,
    M_RELOC_COUNT = 16'h0400,
    M_RELOC_TGT   = 16'h0800,
    M_RELOC_OFS   = 16'h1000,
    M_SYM_LEN     = 16'h2000,
    M_SYM_NAME    = 16'h4000,
    M_SYM_VALUE   = 16'h8000
  } hep_mode_t;

  hep_mode_t   mode_r,   mode_nxt;
  logic [31:0] words_r,  words_nxt;
  logic [31:0] tgt_r,    tgt_nxt;
  logic [15:0] hunk_r,   hunk_nxt;
  logic [31:0] pos_r,    pos_nxt;
  logic [31:0] tleft_r,  tleft_nxt;
  logic [15:0] tpos_r,   tpos_nxt;
  logic        halted_r, halted_nxt;

  logic [31:0] after;
  logic [31:0] words_dec;
  logic [31:0] tleft_dec;

  always_comb begin
    mode_nxt   = mode_r;
    words_nxt  = words_r;
    tgt_nxt    = tgt_r;
    hunk_nxt   = hunk_r;
    pos_nxt    = pos_r;
    tleft_nxt  = tleft_r;
    tpos_nxt   = tpos_r;
    halted_nxt = halted_r;
    emit       = 1'b0;
    res        = '{kind: KIND_SIZE, hunk_index: 16'd0, dest_hunk: 32'd0, value: 32'd0};
    after      = pos_r + 32'd4;
    words_dec  = words_r - 32'd1;
    tleft_dec  = tleft_r - 32'd1;

    if (!halted_r) begin
      pos_nxt = after;
      unique case (mode_r)
        M_TYPE: begin
          if (word == TYPE_HEADER) begin
            mode_nxt = M_LIB_LEN;
          end else if (word == TYPE_CODE || word == TYPE_DATA) begin
            mode_nxt = M_CODE_SIZE;
          end else if (word == TYPE_BSS) begin
            mode_nxt = M_BSS_SIZE;
          end else if (word == TYPE_RELOC) begin
            mode_nxt = M_RELOC_COUNT;
          end else if (word == TYPE_SYMBOL) begin
            mode_nxt = M_SYM_LEN;
          end else if (word == TYPE_END) begin
            hunk_nxt = hunk_r + 16'd1;
          end else begin
            // unknown type word: report it once, then drop everything
            halted_nxt = 1'b1;
            emit       = 1'b1;
            res.kind   = KIND_ERROR;
            res.value  = word;
          end
        end
        M_LIB_LEN: begin
          if (word == 32'd0) begin
            mode_nxt = M_TBL_SIZE;
          end else begin
            words_nxt = word;
            mode_nxt  = M_LIB_SKIP;
          end
        end
        M_LIB_SKIP: begin
          words_nxt = words_dec;
          if (words_dec == 32'd0) mode_nxt = M_LIB_LEN;
        end
        M_TBL_SIZE: begin
          tleft_nxt = word;
          tpos_nxt  = 16'd0;
          mode_nxt  = M_FIRST;
        end
        M_FIRST: begin
          mode_nxt = M_LAST;
        end
        M_LAST: begin
          mode_nxt = (tleft_r == 32'd0) ? M_TYPE : M_TABLE;
        end
        M_TABLE: begin
          emit           = 1'b1;
          res.kind       = KIND_SIZE;
          res.hunk_index = tpos_r;
          res.value      = word;
          tpos_nxt       = tpos_r + 16'd1;
          tleft_nxt      = tleft_dec;
          if (tleft_dec == 32'd0) mode_nxt = M_TYPE;
        end
        M_CODE_SIZE: begin
          emit           = 1'b1;
          res.kind       = KIND_START;
          res.hunk_index = hunk_r;
          res.value      = after;
          words_nxt      = word;
          mode_nxt       = (word == 32'd0) ? M_TYPE : M_CONTENT;
        end
        M_BSS_SIZE: begin
          emit           = 1'b1;
          res.kind       = KIND_START;
          res.hunk_index = hunk_r;
          res.value      = after;
          mode_nxt       = M_TYPE;
        end
        M_CONTENT: begin
          words_nxt = words_dec;
          if (words_dec == 32'd0) mode_nxt = M_TYPE;
        end
        M_RELOC_COUNT: begin
          if (word == 32'd0) begin
            mode_nxt = M_TYPE;
          end else begin
            words_nxt = word;
            mode_nxt  = M_RELOC_TGT;
          end
        end
        M_RELOC_TGT: begin
          tgt_nxt  = word;
          mode_nxt = M_RELOC_OFS;
        end
        M_RELOC_OFS: begin
          emit           = 1'b1;
          res.kind       = KIND_RELOC;
          res.hunk_index = hunk_r;
          res.dest_hunk  = tgt_r;
          res.value      = word;
          words_nxt      = words_dec;
          if (words_dec == 32'd0) mode_nxt = M_RELOC_COUNT;
        end
        M_SYM_LEN: begin
          if (word == 32'd0) begin
            mode_nxt = M_TYPE;
          end else begin
            words_nxt = word;
            mode_nxt  = M_SYM_NAME;
          end
        end
        M_SYM_NAME: begin
          words_nxt = words_dec;
          if (words_dec == 32'd0) mode_nxt = M_SYM_VALUE;
        end
        M_SYM_VALUE: begin
          mode_nxt = M_SYM_LEN;
        end
        default: begin
          mode_nxt = M_SYM_LEN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_TYPE;
      words_r  <= 32'd0;
      tgt_r    <= 32'd0;
      hunk_r   <= 16'd0;
      pos_r    <= 32'd0;
      tleft_r  <= 32'd0;
      tpos_r   <= 16'd0;
      halted_r <= 1'b0;
    end else if (take) begin
      mode_r   <= mode_nxt;
      words_r  <= words_nxt;
      tgt_r    <= tgt_nxt;
      hunk_r   <= hunk_nxt;
      pos_r    <= pos_nxt;
      tleft_r  <= tleft_nxt;
      tpos_r   <= tpos_nxt;
      halted_r <= halted_nxt;
    end
  end

  `HEP_ASSERT_NEXT(a_halt_sticky, halted_r, halted_r, "halt flag cleared without reset")
  `HEP_ASSERT_NOW(a_quiet_halted, halted_r, !emit, "result formed while halted")
  `HEP_ASSERT_NEXT(a_error_halts, take && emit && res.kind == KIND_ERROR, halted_r, "error did not halt")
  `HEP_ASSERT_NEXT(a_pos_step, take && !halted_r, pos_r == $past(pos_r) + 32'd4, "byte position skipped")

endmodule

// ----- sv/hep_out_reg.sv -----
// Result register of the hunk parser: holds one result until taken.
// Depends on hep_pkg.
module hep_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  hep_pkg::hep_result_t res,
  output logic                free,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_kind,
  output logic [15:0]         out_hunk_index,
  output logic [31:0]         out_dest_hunk,
  output logic [31:0]         out_value
);
  import hep_pkg::*;

  logic        valid_r;
  hep_result_t res_r;

  assign free           = !valid_r || out_ready;
  assign out_valid      = valid_r;
  assign out_kind       = res_r.kind;
  assign out_hunk_index = res_r.hunk_index;
  assign out_dest_hunk  = res_r.dest_hunk;
  assign out_value      = res_r.value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule
